// ----- design/erfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder response frame parser package
// Shared types, codes and the CRC-16 byte update of the frame parser.
// ----------------------------------------------------------------------------
package erfp_pkg;

  localparam int MAX_FRAME_DEF = 256;
  localparam int MIN_FRAME     = 11;
  localparam int CFG_IDX_W     = 3;

  localparam logic [31:0] AXLE_WRAP = 32'h0040_0000;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic [7:0] ADDR_BACK  = 8'h01;
  localparam logic [7:0] ADDR_AXLE  = 8'h02;
  localparam logic [7:0] ADDR_FRONT = 8'h03;

  localparam logic [31:0] READ_MIN_RST     = 32'h0000_0000;
  localparam logic [31:0] READ_MAX_RST     = 32'hFFFF_FFFF;
  localparam logic [31:0] AXLE_ZERO_RST    = 32'h0000_0000;
  localparam logic [31:0] BACK_OFFSET_RST  = 32'sd30;
  localparam logic [31:0] FRONT_OFFSET_RST = -32'sd210;
  localparam logic [31:0] AXLE_OFFSET_RST  = -32'sd4109;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_READ_MIN     = 3'd0,
    REG_READ_MAX     = 3'd1,
    REG_AXLE_ZERO    = 3'd2,
    REG_BACK_OFFSET  = 3'd3,
    REG_FRONT_OFFSET = 3'd4,
    REG_AXLE_OFFSET  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_UPDATED = 3'd0,
    ST_CRC_ERR = 3'd1,
    ST_RANGE   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_SHORT   = 3'd4
  } frame_status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  frame_status;
    logic [7:0]  encoder_id;
    logic [31:0] position;
    logic [7:0]  direction;
    logic [15:0] speed_rpm;
    logic [31:0] update_count;
  } out_req_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [31:0]          wdata;
  } cfg_req_t;

  // Contents of one finished frame, handed from the byte stage to the checks.
  typedef struct packed {
    logic        short_frame;
    logic        crc_ok;
    logic [7:0]  addr;
    logic [31:0] count;
    logic [7:0]  dir;
    logic [15:0] rpm;
  } frame_snap_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- design/erfp_if.sv -----
// ----------------------------------------------------------------------------
// Encoder response frame parser channels
// Valid/ready channels for received bytes, frame results and register writes.
// ----------------------------------------------------------------------------
interface erfp_in_if;
  logic             valid;
  logic             ready;
  erfp_pkg::in_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface erfp_out_if;
  logic               valid;
  logic               ready;
  erfp_pkg::out_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface erfp_cfg_if;
  logic               valid;
  logic               ready;
  erfp_pkg::cfg_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/erfp_frame.sv -----
// ----------------------------------------------------------------------------
// Encoder response frame byte stage
// Runs the CRC-16 and captures the frame fields one byte per request.
// ----------------------------------------------------------------------------
module erfp_frame #(
  parameter int MAX_FRAME = erfp_pkg::MAX_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_end,
  output erfp_pkg::frame_snap_t snap
);

  localparam int IDX_W = $clog2(MAX_FRAME + 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_FRAME);
  localparam logic [IDX_W-1:0] IDX_MIN = IDX_W'(erfp_pkg::MIN_FRAME);

  logic [15:0]      crc_r, crc_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [31:0]      count_r, count_nxt;
  logic [7:0]       dir_r, dir_nxt;
  logic [15:0]      rpm_r, rpm_nxt;
  logic             room;

  always_comb begin
    room      = idx_r < IDX_MAX;
    crc_nxt   = crc_r;
    idx_nxt   = idx_r;
    addr_nxt  = addr_r;
    count_nxt = count_r;
    dir_nxt   = dir_r;
    rpm_nxt   = rpm_r;
    if (room) begin
      crc_nxt = erfp_pkg::crc16_byte(crc_r, rx_byte);
      idx_nxt = idx_r + IDX_W'(1);
      if (idx_r == IDX_W'(0)) begin
        addr_nxt = rx_byte;
      end else if (idx_r >= IDX_W'(3) && idx_r <= IDX_W'(6)) begin
        count_nxt = {count_r[23:0], rx_byte};
      end else if (idx_r == IDX_W'(8)) begin
        dir_nxt = rx_byte;
      end else if (idx_r == IDX_W'(9) || idx_r == IDX_W'(10)) begin
        rpm_nxt = {rpm_r[7:0], rx_byte};
      end
    end
  end

  assign snap.short_frame = idx_nxt < IDX_MIN;
  assign snap.crc_ok      = crc_nxt == 16'h0000;
  assign snap.addr        = addr_nxt;
  assign snap.count       = count_nxt;
  assign snap.dir         = dir_nxt;
  assign snap.rpm         = rpm_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (take && frame_end)) begin
      crc_r   <= erfp_pkg::CRC_INIT;
      idx_r   <= '0;
      addr_r  <= '0;
      count_r <= '0;
      dir_r   <= '0;
      rpm_r   <= '0;
    end else if (take) begin
      crc_r   <= crc_nxt;
      idx_r   <= idx_nxt;
      addr_r  <= addr_nxt;
      count_r <= count_nxt;
      dir_r   <= dir_nxt;
      rpm_r   <= rpm_nxt;
    end
  end

endmodule

// ----- design/encoder_response_frame_parser.sv -----
// ----------------------------------------------------------------------------
// Encoder response frame parser
// Checks Modbus CRC-16 response frames from three encoders and reports the
// corrected position, direction, speed and update count at every frame end.
// ----------------------------------------------------------------------------
//   Channel  Dir  Request                     Fires
//   in_if    in   rx_byte, frame_end          every received byte
//   out_if   out  status, id, position, ...   one per frame-end byte
//   cfg_if   in   reg_index, wdata            register write, always ready
//
// One byte is taken per cycle while in_if is ready. A result passes from its
// frame-end byte through the byte stage, the range and sum stage, then the output register.
// Up to three results can wait in the pipeline while out_if stalls; only
// then does in_if drop ready. Reset clears the frame state, the counters,
// the pipeline valids and loads the register reset values.
// ----------------------------------------------------------------------------
module encoder_response_frame_parser #(
  parameter int MAX_FRAME = erfp_pkg::MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  erfp_in_if.sink    in_if,
  erfp_out_if.source out_if,
  erfp_cfg_if.sink   cfg_if
);

  logic [31:0] read_min_r, read_max_r, axle_zero_r;
  logic [31:0] back_off_r, front_off_r, axle_off_r, axle_off_w_r;
  logic [31:0] counters_r [3];

  logic take;
  erfp_pkg::frame_snap_t snap;

  logic                  s1_v_r;
  erfp_pkg::frame_snap_t s1_r;
  logic                  s2_v_r;
  erfp_pkg::frame_snap_t s2_r;
  logic                  s2_in_range_r;
  logic                  s2_wrap_r;
  logic [31:0]           s2_sum_r;
  logic [31:0]           sum_nxt;

  logic               out_v_r;
  erfp_pkg::out_req_t out_r, out_nxt;
  logic               out_free, s2_free, s1_free;
  logic [1:0]         slot;
  logic               bump;
  logic [31:0]        cnt_inc;

  // Configuration registers.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_min_r   <= erfp_pkg::READ_MIN_RST;
      read_max_r   <= erfp_pkg::READ_MAX_RST;
      axle_zero_r  <= erfp_pkg::AXLE_ZERO_RST;
      back_off_r   <= erfp_pkg::BACK_OFFSET_RST;
      front_off_r  <= erfp_pkg::FRONT_OFFSET_RST;
      axle_off_r   <= erfp_pkg::AXLE_OFFSET_RST;
      axle_off_w_r <= erfp_pkg::AXLE_OFFSET_RST - erfp_pkg::AXLE_WRAP;
    end else if (cfg_if.valid) begin
      case (cfg_if.payload.reg_index)
        erfp_pkg::REG_READ_MIN:     read_min_r  <= cfg_if.payload.wdata;
        erfp_pkg::REG_READ_MAX:     read_max_r  <= cfg_if.payload.wdata;
        erfp_pkg::REG_AXLE_ZERO:    axle_zero_r <= cfg_if.payload.wdata;
        erfp_pkg::REG_BACK_OFFSET:  back_off_r  <= cfg_if.payload.wdata;
        erfp_pkg::REG_FRONT_OFFSET: front_off_r <= cfg_if.payload.wdata;
        erfp_pkg::REG_AXLE_OFFSET: begin
          axle_off_r   <= cfg_if.payload.wdata;
          axle_off_w_r <= cfg_if.payload.wdata - erfp_pkg::AXLE_WRAP;
        end
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  assign out_free    = !out_v_r || out_if.ready;
  assign s2_free     = !s2_v_r || out_free;
  assign s1_free     = !s1_v_r || s2_free;
  assign in_if.ready = s1_free;
  assign take        = in_if.valid && s1_free;

  erfp_frame #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_if.payload.rx_byte),
    .frame_end (in_if.payload.frame_end),
    .snap      (snap)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= take && in_if.payload.frame_end;
    end
    if (take && in_if.payload.frame_end) begin
      s1_r <= snap;
    end
  end

  // Range window and axle sum.
  assign sum_nxt = s1_r.count + axle_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
    if (s1_v_r && s2_free) begin
      s2_r          <= s1_r;
      s2_in_range_r <= (s1_r.count > read_min_r) && (s1_r.count < read_max_r);
      s2_sum_r      <= sum_nxt;
      s2_wrap_r     <= sum_nxt > erfp_pkg::AXLE_WRAP;
    end
  end

  // Frame verdict, position and update counter.
  always_comb begin
    slot    = 2'd1;
    bump    = 1'b0;
    cnt_inc = '0;
    out_nxt.frame_status = erfp_pkg::ST_UNKNOWN;
    out_nxt.encoder_id   = s2_r.addr;
    out_nxt.position     = '0;
    out_nxt.direction    = s2_r.dir;
    out_nxt.speed_rpm    = s2_r.rpm;
    out_nxt.update_count = '0;
    if (s2_r.addr == erfp_pkg::ADDR_BACK) begin
      slot = 2'd0;
    end else if (s2_r.addr == erfp_pkg::ADDR_FRONT) begin
      slot = 2'd2;
    end
    cnt_inc = counters_r[slot] + 32'd1;
    if (s2_r.short_frame) begin
      out_nxt.frame_status = erfp_pkg::ST_SHORT;
    end else if (!s2_r.crc_ok) begin
      out_nxt.frame_status = erfp_pkg::ST_CRC_ERR;
    end else if (s2_r.addr == erfp_pkg::ADDR_BACK || s2_r.addr == erfp_pkg::ADDR_FRONT) begin
      if (s2_in_range_r) begin
        bump                 = 1'b1;
        out_nxt.frame_status = erfp_pkg::ST_UPDATED;
        out_nxt.update_count = cnt_inc;
        out_nxt.position     = s2_r.count +
                               ((s2_r.addr == erfp_pkg::ADDR_BACK) ? back_off_r : front_off_r);
      end else begin
        out_nxt.frame_status = erfp_pkg::ST_RANGE;
        out_nxt.update_count = counters_r[slot];
      end
    end else if (s2_r.addr == erfp_pkg::ADDR_AXLE) begin
      bump                 = 1'b1;
      out_nxt.frame_status = erfp_pkg::ST_UPDATED;
      out_nxt.update_count = cnt_inc;
      out_nxt.position     = s2_sum_r + (s2_wrap_r ? axle_off_w_r : axle_off_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r       <= 1'b0;
      counters_r[0] <= '0;
      counters_r[1] <= '0;
      counters_r[2] <= '0;
    end else begin
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
      if (s2_v_r && out_free && bump) begin
        counters_r[slot] <= cnt_inc;
      end
    end
    if (s2_v_r && out_free) begin
      out_r <= out_nxt;
    end
  end

  assign out_if.valid   = out_v_r;
  assign out_if.payload = out_r;

endmodule

// ----- tb/encoder_response_frame_parser_test.sv -----
// ----------------------------------------------------------------------------
// Encoder response frame parser testbench
// Streams Modbus response frames (good, corrupted, short, unknown address and
// overlong) into the parser under changing register settings and random
// backpressure. Each frame report is checked against a cycle-free prediction.
// ----------------------------------------------------------------------------
module encoder_response_frame_parser_test;

  typedef logic [7:0] byte_q_t[$];

  localparam int HOLD_CYCLES    = 150;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [erfp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  erfp_in_if  in_ch ();
  erfp_out_if out_ch ();
  erfp_cfg_if cfg_ch ();

  encoder_response_frame_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  erfp_pkg::in_req_t  rx_backlog[$];
  erfp_pkg::out_req_t frame_reports[$];
  int unsigned        mismatch_count = 0;
  int unsigned        send_idle_pct  = 0;
  int unsigned        recv_idle_pct  = 0;
  bit                 hold_req       = 1'b0;
  bit                 hold_ack;
  int unsigned        hold_left;
  int unsigned        quiet_cycles;
  erfp_pkg::out_req_t want;

  logic [31:0] win_lo, win_hi, axle_zero_cfg, back_ofs, front_ofs, axle_ofs;
  logic [15:0] crc_acc;
  int          rx_len;
  logic [7:0]  addr_cap, dir_cap;
  logic [31:0] count_cap;
  logic [15:0] rpm_cap;
  logic [31:0] upd_cnt[3];

  function automatic logic [15:0] modbus_crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ erfp_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic clear_frame_capture();
    crc_acc   = erfp_pkg::CRC_INIT;
    rx_len    = 0;
    addr_cap  = '0;
    count_cap = '0;
    dir_cap   = '0;
    rpm_cap   = '0;
  endtask

  task automatic apply_reg(input logic [erfp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    case (idx)
      erfp_pkg::REG_READ_MIN:     win_lo        = value;
      erfp_pkg::REG_READ_MAX:     win_hi        = value;
      erfp_pkg::REG_AXLE_ZERO:    axle_zero_cfg = value;
      erfp_pkg::REG_BACK_OFFSET:  back_ofs      = value;
      erfp_pkg::REG_FRONT_OFFSET: front_ofs     = value;
      erfp_pkg::REG_AXLE_OFFSET:  axle_ofs      = value;
      default: ;
    endcase
  endtask

  task automatic parse_rx_byte(input erfp_pkg::in_req_t req);
    erfp_pkg::out_req_t res;
    logic [31:0]        sum;
    int                 slot;
    if (rx_len < erfp_pkg::MAX_FRAME_DEF) begin
      crc_acc = modbus_crc_next(crc_acc, req.rx_byte);
      if (rx_len == 0) begin
        addr_cap = req.rx_byte;
      end else if (rx_len >= 3 && rx_len <= 6) begin
        count_cap = {count_cap[23:0], req.rx_byte};
      end else if (rx_len == 8) begin
        dir_cap = req.rx_byte;
      end else if (rx_len == 9 || rx_len == 10) begin
        rpm_cap = {rpm_cap[7:0], req.rx_byte};
      end
      rx_len++;
    end
    if (!req.frame_end) return;
    res            = '0;
    res.encoder_id = addr_cap;
    res.direction  = dir_cap;
    res.speed_rpm  = rpm_cap;
    if (rx_len < erfp_pkg::MIN_FRAME) begin
      res.frame_status = erfp_pkg::ST_SHORT;
    end else if (crc_acc != 16'h0000) begin
      res.frame_status = erfp_pkg::ST_CRC_ERR;
    end else if (addr_cap == erfp_pkg::ADDR_BACK || addr_cap == erfp_pkg::ADDR_FRONT) begin
      slot = (addr_cap == erfp_pkg::ADDR_BACK) ? 0 : 2;
      if (count_cap > win_lo && count_cap < win_hi) begin
        upd_cnt[slot]++;
        res.frame_status = erfp_pkg::ST_UPDATED;
        res.position     = count_cap +
                           ((addr_cap == erfp_pkg::ADDR_BACK) ? back_ofs : front_ofs);
      end else begin
        res.frame_status = erfp_pkg::ST_RANGE;
      end
      res.update_count = upd_cnt[slot];
    end else if (addr_cap == erfp_pkg::ADDR_AXLE) begin
      sum = count_cap + axle_zero_cfg;
      if (sum > erfp_pkg::AXLE_WRAP) sum = sum - erfp_pkg::AXLE_WRAP;
      upd_cnt[1]++;
      res.frame_status = erfp_pkg::ST_UPDATED;
      res.position     = sum + axle_ofs;
      res.update_count = upd_cnt[1];
    end else begin
      res.frame_status = erfp_pkg::ST_UNKNOWN;
    end
    frame_reports.push_back(res);
    clear_frame_capture();
  endtask

  task automatic compare_field(input string label, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, exp_val, got_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) parse_rx_byte(in_ch.payload);
      if (!in_ch.valid || in_ch.ready) begin
        if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.payload <= rx_backlog.pop_front();
          in_ch.valid   <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_ack     = hold_req;
      hold_left    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frame_reports.size() == 0) begin
          $display("%0t: unexpected frame report, expected none, actual %h",
                   $time, out_ch.payload);
          mismatch_count++;
        end else begin
          want = frame_reports.pop_front();
          compare_field("frame_status", 32'(want.frame_status),
                        32'(out_ch.payload.frame_status));
          compare_field("encoder_id", 32'(want.encoder_id),
                        32'(out_ch.payload.encoder_id));
          compare_field("position", want.position, out_ch.payload.position);
          compare_field("direction", 32'(want.direction),
                        32'(out_ch.payload.direction));
          compare_field("speed_rpm", 32'(want.speed_rpm),
                        32'(out_ch.payload.speed_rpm));
          compare_field("update_count", want.update_count, out_ch.payload.update_count);
        end
      end
      if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else if (rx_backlog.size() != 0 || in_ch.valid || frame_reports.size() != 0 ||
                 cfg_ch.valid) begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [erfp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_ch.payload <= '{reg_index: idx, wdata: value};
    cfg_ch.valid   <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_reg(idx, value);
  endtask

  task automatic write_all_regs(input logic [31:0] lo, input logic [31:0] hi,
                                input logic [31:0] zero, input logic [31:0] back,
                                input logic [31:0] front, input logic [31:0] axle);
    write_reg(erfp_pkg::REG_READ_MIN, lo);
    write_reg(erfp_pkg::REG_READ_MAX, hi);
    write_reg(erfp_pkg::REG_AXLE_ZERO, zero);
    write_reg(erfp_pkg::REG_BACK_OFFSET, back);
    write_reg(erfp_pkg::REG_FRONT_OFFSET, front);
    write_reg(erfp_pkg::REG_AXLE_OFFSET, axle);
    write_reg(REG_UNMAPPED, $urandom);
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (rx_backlog.size() != 0 || in_ch.valid || frame_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic make_body(input logic [7:0] addr, input logic [31:0] raw, input int n,
                           output byte_q_t body);
    body = {};
    repeat (n) body.push_back(8'($urandom_range(255)));
    body[0] = addr;
    body[3] = raw[31:24];
    body[4] = raw[23:16];
    body[5] = raw[15:8];
    body[6] = raw[7:0];
  endtask

  task automatic queue_frame(input byte_q_t body, input bit add_crc,
                             input logic [15:0] crc_mask, input int tail, output int n_items);
    logic [15:0]       crc;
    byte_q_t           bytes;
    erfp_pkg::in_req_t item;
    bytes = body;
    if (add_crc) begin
      crc = erfp_pkg::CRC_INIT;
      foreach (body[i]) crc = modbus_crc_next(crc, body[i]);
      crc = crc ^ crc_mask;
      bytes.push_back(crc[7:0]);
      bytes.push_back(crc[15:8]);
    end
    repeat (tail) bytes.push_back(8'($urandom_range(255)));
    foreach (bytes[i]) begin
      item.rx_byte   = bytes[i];
      item.frame_end = (i == bytes.size() - 1);
      rx_backlog.push_back(item);
    end
    n_items = bytes.size();
  endtask

  function automatic logic [31:0] pick_raw(input logic [7:0] addr);
    logic [31:0] base;
    if (addr == erfp_pkg::ADDR_AXLE) begin
      base = erfp_pkg::AXLE_WRAP - axle_zero_cfg;
    end else begin
      base = $urandom_range(1) ? win_lo : win_hi;
    end
    case ($urandom_range(5))
      0: return base - 32'd1;
      1: return base;
      2: return base + 32'd1;
      3: return win_lo + 32'd2 + $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_frames(input int budget, input bit with_overlong);
    int          queued;
    int          n;
    int unsigned kind;
    logic [7:0]  addr;
    byte_q_t     body;
    queued = 0;
    while (queued < budget) begin
      kind = $urandom_range(99);
      if (kind >= 82 && kind < 90) begin
        addr = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255, 4));
      end else begin
        addr = 8'($urandom_range(3, 1));
      end
      make_body(addr, pick_raw(addr), $urandom_range(13, 9), body);
      if (kind < 62 || (kind >= 82 && kind < 90)) begin
        queue_frame(body, 1'b1, 16'h0000, 0, n);
      end else if (kind < 72) begin
        queue_frame(body, 1'b1, 16'($urandom_range(16'hFFFF, 1)), 0, n);
      end else if (kind < 82) begin
        body = body[0:$urandom_range(7)];
        queue_frame(body, 1'($urandom_range(1)), 16'h0000, 0, n);
      end else begin
        queue_frame(body, 1'b0, 16'h0000, $urandom_range(6), n);
      end
      queued += n;
    end
    if (with_overlong) begin
      addr = 8'($urandom_range(3, 1));
      make_body(addr, pick_raw(addr), erfp_pkg::MAX_FRAME_DEF - 2, body);
      queue_frame(body, 1'b1, 16'h0000, 3, n);
    end
  endtask

  initial begin
    byte_q_t     body;
    int          n;
    logic [31:0] lo;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    rst_n          = 1'b0;
    win_lo         = erfp_pkg::READ_MIN_RST;
    win_hi         = erfp_pkg::READ_MAX_RST;
    axle_zero_cfg  = erfp_pkg::AXLE_ZERO_RST;
    back_ofs       = erfp_pkg::BACK_OFFSET_RST;
    front_ofs      = erfp_pkg::FRONT_OFFSET_RST;
    axle_ofs       = erfp_pkg::AXLE_OFFSET_RST;
    upd_cnt        = '{default: '0};
    clear_frame_capture();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 27;
    recv_idle_pct = 81;
    body = {};
    body.push_back(8'hFF);
    queue_frame(body, 1'b0, 16'h0000, 0, n);
    make_body(erfp_pkg::ADDR_AXLE, 32'hFFFF_FFFF, 9, body);
    queue_frame(body, 1'b1, 16'h0000, 0, n);
    make_body(erfp_pkg::ADDR_FRONT, 32'h0000_0000, 9, body);
    queue_frame(body, 1'b1, 16'h0000, 0, n);
    wait_until_drained();

    lo = $urandom >> 1;
    write_all_regs(lo, lo + $urandom_range(4096, 16), $urandom, $urandom, $urandom, $urandom);
    queue_random_frames(95, 1'b0);
    wait_until_drained();

    send_idle_pct = 81;
    recv_idle_pct = 27;
    write_all_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000);
    queue_random_frames(95, 1'b0);
    wait_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all_regs($urandom_range(255), $urandom, $urandom, $urandom, $urandom, 32'h7FFF_FFFF);
    hold_req = !hold_req;
    queue_random_frames(70, 1'b1);
    wait_until_drained();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
